// ===== hdl/vsa_pkg.sv =====
// Package for the volume source arbiter: request and result types, register
// map, state record and the percent / 0-127 scale conversions.
// No dependencies.
package vsa_pkg;

  // Register map, word index taken from paddr[3:2]
  localparam logic [1:0] REG_MOVE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HANDBACK_TICKS = 2'd1;
  localparam logic [1:0] REG_MAX_VOLUME     = 2'd2;
  localparam logic [1:0] REG_SAFE_VOLUME    = 2'd3;

  localparam logic [6:0]  PCT_FULL           = 7'd100;
  localparam logic [6:0]  RST_MOVE_THRESHOLD = 7'd7;
  localparam logic [31:0] RST_HANDBACK_TICKS = 32'd30000;
  localparam logic [6:0]  RST_MAX_VOLUME     = 7'd90;
  localparam logic [6:0]  RST_SAFE_VOLUME    = 7'd80;
  localparam logic [6:0]  RST_VOLUME         = 7'd50;

  // Reciprocal multipliers: 127/100 ~ 665861 / 2^19, 100/127 ~ 13210500 / 2^24
  localparam logic [26:0] LEVEL_MUL = 27'd665861;
  localparam logic [30:0] PCT_MUL   = 31'd13210500;

  typedef struct packed {
    logic [6:0]  knob_percent;
    logic        phone_update;
    logic [6:0]  phone_level;
    logic [31:0] now_ticks;
    logic        preset_aggressive;
  } in_item_t;

  typedef struct packed {
    logic [6:0] volume_percent;
    logic       volume_applied;
    logic       send_level;
    logic [6:0] level_to_send;
    logic       force_normal;
    logic       knob_in_control;
  } out_item_t;

  // Settings seen by the decision logic; cap and phone_lim are derived
  typedef struct packed {
    logic [6:0]  move_threshold;
    logic [31:0] handback_ticks;
    logic [6:0]  safe_volume;
    logic [6:0]  cap;
    logic [6:0]  phone_lim;
  } cfg_t;

  typedef struct packed {
    logic        knob_owns;
    logic [6:0]  current_volume;
    logic        knob_valid;
    logic [6:0]  last_knob;
    logic        phone_valid;
    logic [6:0]  last_phone;
    logic [31:0] last_move_time;
  } state_t;

  // pct * 127 / 100, truncated; exact for pct up to 100
  function automatic logic [6:0] to_level(input logic [6:0] pct);
    logic [26:0] prod;
    prod = 27'(pct) * LEVEL_MUL;
    return prod[25:19];
  endfunction

  // lvl * 100 / 127, truncated; exact over the whole 0-127 range
  function automatic logic [6:0] to_percent(input logic [6:0] lvl);
    logic [30:0] prod;
    prod = 31'(lvl) * PCT_MUL;
    return prod[30:24];
  endfunction

endpackage

// ===== hdl/vsa_regs.sv =====
// APB-style register block of the volume source arbiter.
// Keeps the four settings and the derived ceiling / phone limit.
// Depends on vsa_pkg.
module vsa_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output vsa_pkg::cfg_t      cfg
);

  logic [6:0]  move_threshold_r, move_threshold_nxt;
  logic [31:0] handback_ticks_r, handback_ticks_nxt;
  logic [6:0]  max_volume_r, max_volume_nxt;
  logic [6:0]  safe_volume_r, safe_volume_nxt;
  logic [6:0]  cap_r, cap_nxt;
  logic [6:0]  lim_r, lim_nxt;
  logic        wr_en;
  logic [6:0]  wr_cap;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  // ceiling above full scale acts as full scale
  assign wr_cap = (pwdata[6:0] > vsa_pkg::PCT_FULL) ? vsa_pkg::PCT_FULL : pwdata[6:0];

  always_comb begin
    move_threshold_nxt = move_threshold_r;
    handback_ticks_nxt = handback_ticks_r;
    max_volume_nxt     = max_volume_r;
    safe_volume_nxt    = safe_volume_r;
    cap_nxt            = cap_r;
    lim_nxt            = lim_r;
    if (wr_en) begin
      unique case (paddr[3:2])
        vsa_pkg::REG_MOVE_THRESHOLD: move_threshold_nxt = pwdata[6:0];
        vsa_pkg::REG_HANDBACK_TICKS: handback_ticks_nxt = pwdata;
        vsa_pkg::REG_MAX_VOLUME: begin
          max_volume_nxt = pwdata[6:0];
          cap_nxt        = wr_cap;
          lim_nxt        = vsa_pkg::to_level(wr_cap);
        end
        vsa_pkg::REG_SAFE_VOLUME: safe_volume_nxt = pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_threshold_r <= vsa_pkg::RST_MOVE_THRESHOLD;
      handback_ticks_r <= vsa_pkg::RST_HANDBACK_TICKS;
      max_volume_r     <= vsa_pkg::RST_MAX_VOLUME;
      safe_volume_r    <= vsa_pkg::RST_SAFE_VOLUME;
      cap_r            <= vsa_pkg::RST_MAX_VOLUME;
      lim_r            <= vsa_pkg::to_level(vsa_pkg::RST_MAX_VOLUME);
    end else begin
      move_threshold_r <= move_threshold_nxt;
      handback_ticks_r <= handback_ticks_nxt;
      max_volume_r     <= max_volume_nxt;
      safe_volume_r    <= safe_volume_nxt;
      cap_r            <= cap_nxt;
      lim_r            <= lim_nxt;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      vsa_pkg::REG_MOVE_THRESHOLD: prdata = {25'd0, move_threshold_r};
      vsa_pkg::REG_HANDBACK_TICKS: prdata = handback_ticks_r;
      vsa_pkg::REG_MAX_VOLUME:     prdata = {25'd0, max_volume_r};
      vsa_pkg::REG_SAFE_VOLUME:    prdata = {25'd0, safe_volume_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.move_threshold = move_threshold_r;
  assign cfg.handback_ticks = handback_ticks_r;
  assign cfg.safe_volume    = safe_volume_r;
  assign cfg.cap            = cap_r;
  assign cfg.phone_lim      = lim_r;

endmodule

// ===== hdl/vsa_step.sv =====
// Decision logic for one poll: next arbiter state and the result record.
// Purely combinational; depends on vsa_pkg.
module vsa_step (
  input  vsa_pkg::in_item_t  item,
  input  vsa_pkg::state_t    st,
  input  vsa_pkg::cfg_t      cfg,
  output vsa_pkg::state_t    st_nxt,
  output vsa_pkg::out_item_t res
);

  logic [6:0]  phone_clamped;
  logic [6:0]  phone_pct;
  logic [6:0]  phone_val;
  logic        phone_vld;
  logic        phone_apply;
  logic        handback;
  logic [31:0] elapsed;
  logic [6:0]  knob_delta;
  logic        moved;
  logic [6:0]  knob_vol;
  logic [6:0]  mid_volume;
  logic        force_phone;
  logic        force_knob;
  logic [6:0]  level;

  assign phone_clamped = (item.phone_level > cfg.phone_lim) ? cfg.phone_lim : item.phone_level;
  assign phone_pct     = vsa_pkg::to_percent(phone_clamped);
  assign phone_val     = item.phone_update ? phone_pct : st.last_phone;
  assign phone_vld     = item.phone_update || st.phone_valid;

  assign phone_apply = !st.knob_owns && phone_vld && (phone_val != st.current_volume);
  assign elapsed     = item.now_ticks - st.last_move_time;
  assign handback    = st.knob_owns && (elapsed > cfg.handback_ticks);
  assign mid_volume  = phone_apply ? phone_val : st.current_volume;
  assign force_phone = phone_apply && item.preset_aggressive && (phone_val > cfg.safe_volume);

  assign knob_delta = (item.knob_percent > st.last_knob) ? (item.knob_percent - st.last_knob)
                                                          : (st.last_knob - item.knob_percent);
  assign moved      = !st.knob_valid || (knob_delta > cfg.move_threshold);
  assign knob_vol   = (item.knob_percent > cfg.cap) ? cfg.cap : item.knob_percent;
  assign force_knob = moved && item.preset_aggressive && (knob_vol > cfg.safe_volume);

  // handback reports the held volume; a knob move overrides it
  assign level = vsa_pkg::to_level(moved ? knob_vol : st.current_volume);

  always_comb begin
    st_nxt = st;
    if (phone_apply) begin
      st_nxt.current_volume = phone_val;
    end
    st_nxt.last_phone  = phone_val;
    st_nxt.phone_valid = phone_vld;
    if (handback) begin
      st_nxt.knob_owns   = 1'b0;
      st_nxt.last_phone  = st.current_volume;
      st_nxt.phone_valid = 1'b1;
    end
    if (moved) begin
      st_nxt.last_knob      = item.knob_percent;
      st_nxt.knob_valid     = 1'b1;
      st_nxt.knob_owns      = 1'b1;
      st_nxt.last_move_time = item.now_ticks;
      st_nxt.current_volume = knob_vol;
    end
  end

  assign res.volume_percent  = moved ? knob_vol : mid_volume;
  assign res.volume_applied  = phone_apply || moved;
  assign res.send_level      = handback || moved;
  assign res.level_to_send   = (handback || moved) ? level : 7'd0;
  assign res.force_normal    = force_phone || force_knob;
  assign res.knob_in_control = moved || (st.knob_owns && !handback);

endmodule

// ===== hdl/volume_source_arbiter.sv =====
// Top level of the volume source arbiter: request register, decision logic,
// result register and arbiter state. Depends on vsa_pkg, vsa_regs, vsa_step.
//
// Channel   Direction  Handshake              Payload
// in_       request    in_valid / in_stall    vsa_pkg::in_item_t
// out_      result     out_valid / out_stall  vsa_pkg::out_item_t
// cfg       APB write  psel, penable, pwrite  4 registers at 4*i, 32-bit data
//
// One request per clock sustained while out_stall is low. A request is held in the
// input register, is decided there and is written to the result register when that
// register is free; the arbiter state updates on that same edge. in_stall rises
// only while both the input and result registers hold work and out_stall is high.
// Reset (rst_n low, synchronous) empties both stages and restores the state
// and settings to their power-on values.
module volume_source_arbiter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vsa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vsa_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  vsa_pkg::cfg_t      cfg;
  vsa_pkg::in_item_t  a_item_r;
  logic               a_valid_r, a_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  vsa_pkg::out_item_t out_data_r;
  vsa_pkg::state_t    st_r;
  vsa_pkg::state_t    st_nxt;
  vsa_pkg::out_item_t res;
  logic               b_free;
  logic               in_accept;
  logic               advance;

  vsa_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vsa_step u_step (
    .item   (a_item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // result register free when empty or being drained this cycle
  assign b_free    = !out_valid_r || !out_stall;
  assign in_stall  = a_valid_r && !b_free;
  assign in_accept = in_valid && !in_stall;
  assign advance   = a_valid_r && b_free;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (advance) begin
      a_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // arbiter state moves only when a decided poll enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.knob_owns      <= 1'b0;
      st_r.current_volume <= vsa_pkg::RST_VOLUME;
      st_r.knob_valid     <= 1'b0;
      st_r.last_knob      <= 7'd0;
      st_r.phone_valid    <= 1'b0;
      st_r.last_phone     <= 7'd0;
      st_r.last_move_time <= 32'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // level is only carried when a report to the phone is requested
  a_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.send_level |-> out_data.level_to_send == 7'd0)
    else $error("level_to_send nonzero without send_level");

  // preset reset only comes with a newly applied volume
  a_force_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.force_normal |-> out_data.volume_applied)
    else $error("force_normal without volume_applied");

  // volume never leaves the percent range
  a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.volume_percent <= vsa_pkg::PCT_FULL)
    else $error("volume_percent above full scale");

  // backpressure only when both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && out_valid_r && out_stall)
    else $error("input stalled with a free stage");

endmodule
